>>> sv/esh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Endstop homing sequencer package
// Types, codes and reset values shared by the homing sequencer core.
// ----------------------------------------------------------------------------
package esh_pkg;

	// Field widths.
	localparam int unsigned STEPS_W = 24;
	localparam int unsigned MOVE_W  = 25;
	localparam int unsigned MS_W    = 22;
	localparam int unsigned SPEED_W = 16;
	localparam int unsigned CFG_W   = 24;
	localparam int unsigned IDX_W   = 3;

	// Settle time after the pre-clear move, in milliseconds.
	localparam int unsigned SETTLE_MS_DEF = 50;

	// Saturation value of the elapsed millisecond counter.
	localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

	// Register reset values.
	localparam logic [STEPS_W-1:0] FAST_TRAVEL_RST = 24'd48000;
	localparam logic [STEPS_W-1:0] SLOW_TRAVEL_RST = 24'd1600;
	localparam logic [STEPS_W-1:0] BACKOFF_RST     = 24'd400;
	localparam logic [MS_W-1:0]    APPROACH_TO_RST = 22'd30000;
	localparam logic [MS_W-1:0]    BACKOFF_TO_RST  = 22'd1000;
	localparam logic [MS_W-1:0]    PRECLEAR_TO_RST = 22'd1500;
	localparam logic [SPEED_W-1:0] FAST_SPEED_RST  = 16'd4000;
	localparam logic [SPEED_W-1:0] SLOW_SPEED_RST  = 16'd400;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_FAST_TRAVEL = 3'd0,
		REG_SLOW_TRAVEL = 3'd1,
		REG_BACKOFF     = 3'd2,
		REG_APPROACH_TO = 3'd3,
		REG_BACKOFF_TO  = 3'd4,
		REG_PRECLEAR_TO = 3'd5,
		REG_FAST_SPEED  = 3'd6,
		REG_SLOW_SPEED  = 3'd7
	} reg_idx_t;

	// Homing phases.
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_PRECLEAR = 3'd1,
		PH_SETTLE   = 3'd2,
		PH_FAST     = 3'd3,
		PH_FAST_HIT = 3'd4,
		PH_BACKOFF  = 3'd5,
		PH_SLOW     = 3'd6
	} phase_t;

	// Motion generator commands.
	typedef enum logic [2:0] {
		MC_NONE     = 3'd0,
		MC_MOVE_NEG = 3'd1,
		MC_MOVE_POS = 3'd2,
		MC_STOP_DEC = 3'd3,
		MC_STOP_NOW = 3'd4
	} motion_cmd_t;

	// Run status.
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_BUSY = 2'd1,
		ST_DONE = 2'd2,
		ST_FAIL = 2'd3
	} status_t;

	// Failure causes.
	typedef enum logic [3:0] {
		FC_NONE           = 4'd0,
		FC_PRECLEAR_TO    = 4'd1,
		FC_STILL_HIT      = 4'd2,
		FC_FAST_TO        = 4'd3,
		FC_FAST_STALL     = 4'd4,
		FC_BACKOFF_TO     = 4'd5,
		FC_HIT_AFTER_BACK = 4'd6,
		FC_SLOW_TO        = 4'd7,
		FC_SLOW_STALL     = 4'd8
	} fail_cause_t;

	// One result item.
	typedef struct packed {
		motion_cmd_t         motion_cmd;
		logic [MOVE_W-1:0]   move_steps;
		logic [SPEED_W-1:0]  move_speed;
		logic                driver_enable;
		logic                zero_position;
		status_t             status;
		fail_cause_t         fail_cause;
		logic                is_homed;
	} res_t;

endpackage : esh_pkg
`default_nettype wire

>>> sv/endstop_homing_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Endstop homing sequencer core
// One-axis two-pass homing: optional pre-clear, fast approach, backoff and
// slow approach, each with a millisecond timeout; both approaches also detect a stall.
// ----------------------------------------------------------------------------
// Each result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one transaction per cycle while in_stall is low; the phase update is a single pass
// of logic between the state registers and the result register.
// A two-entry result buffer (output register plus skid) keeps input flowing
// while a result waits; input stalls only when both entries are full.
// Reset: asynchronous, active low; idle, not homed, registers at defaults.
module endstop_homing_sequencer_core
	import esh_pkg::*;
#(
	parameter int unsigned SETTLE_MS = SETTLE_MS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Configuration write port.
	input  wire logic               cfg_we,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_wdata,
	// Input channel.
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic               endstop_hit,
	input  wire logic               motion_busy,
	input  wire logic               ms_tick,
	// Output channel.
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              motion_cmd,
	output logic [MOVE_W-1:0]       move_steps,
	output logic [SPEED_W-1:0]      move_speed,
	output logic                    driver_enable,
	output logic                    zero_position,
	output logic [1:0]              status,
	output logic [3:0]              fail_cause,
	output logic                    is_homed
);

	localparam logic [MS_W-1:0] SETTLE_LIMIT = MS_W'(SETTLE_MS);

	// Configuration registers.
	logic [STEPS_W-1:0] fast_travel_q, slow_travel_q, backoff_q;
	logic [MS_W-1:0]    approach_to_q, backoff_to_q, preclear_to_q;
	logic [SPEED_W-1:0] fast_speed_q, slow_speed_q;

	// Sequencer state.
	phase_t          phase_q, phase_d;
	logic [MS_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic            homed_q, homed_d;

	// Result buffer.
	res_t res_d, out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic in_accept;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_travel_q <= FAST_TRAVEL_RST;
			slow_travel_q <= SLOW_TRAVEL_RST;
			backoff_q     <= BACKOFF_RST;
			approach_to_q <= APPROACH_TO_RST;
			backoff_to_q  <= BACKOFF_TO_RST;
			preclear_to_q <= PRECLEAR_TO_RST;
			fast_speed_q  <= FAST_SPEED_RST;
			slow_speed_q  <= SLOW_SPEED_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FAST_TRAVEL: fast_travel_q <= cfg_wdata;
				REG_SLOW_TRAVEL: slow_travel_q <= cfg_wdata;
				REG_BACKOFF:     backoff_q     <= cfg_wdata;
				REG_APPROACH_TO: approach_to_q <= cfg_wdata[MS_W-1:0];
				REG_BACKOFF_TO:  backoff_to_q  <= cfg_wdata[MS_W-1:0];
				REG_PRECLEAR_TO: preclear_to_q <= cfg_wdata[MS_W-1:0];
				REG_FAST_SPEED:  fast_speed_q  <= cfg_wdata[SPEED_W-1:0];
				REG_SLOW_SPEED:  slow_speed_q  <= cfg_wdata[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !in_stall;

	// Sequencer state registers, advanced once per input transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
			homed_q   <= 1'b0;
		end else if (in_accept) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			homed_q   <= homed_d;
		end
	end

	// Next phase and result for the incoming sample.
	always_comb begin
		logic finish;
		logic [3:0] cause;

		finish = 1'b0;
		cause  = FC_NONE;

		// The tick is counted before the phase checks, saturating.
		if (phase_q != PH_IDLE && ms_tick && elapsed_q != MS_MAX) begin
			elapsed_inc = elapsed_q + MS_W'(1);
		end else begin
			elapsed_inc = elapsed_q;
		end

		phase_d   = phase_q;
		elapsed_d = elapsed_inc;
		homed_d   = homed_q;

		res_d                = '0;
		res_d.motion_cmd     = MC_NONE;
		res_d.status         = ST_IDLE;
		res_d.fail_cause     = FC_NONE;

		unique case (phase_q)
			PH_IDLE: begin
				if (command) begin
					elapsed_d        = '0;
					res_d.move_speed = fast_speed_q;
					if (endstop_hit) begin
						res_d.motion_cmd = MC_MOVE_POS;
						res_d.move_steps = {backoff_q, 1'b0};
						phase_d          = PH_PRECLEAR;
					end else begin
						res_d.motion_cmd = MC_MOVE_NEG;
						res_d.move_steps = {1'b0, fast_travel_q};
						phase_d          = PH_FAST;
					end
				end
			end
			PH_PRECLEAR: begin
				if (!motion_busy) begin
					phase_d   = PH_SETTLE;
					elapsed_d = '0;
				end else if (elapsed_inc > preclear_to_q) begin
					finish = 1'b1;
					cause  = FC_PRECLEAR_TO;
				end
			end
			PH_SETTLE: begin
				if (elapsed_inc >= SETTLE_LIMIT) begin
					if (endstop_hit) begin
						finish = 1'b1;
						cause  = FC_STILL_HIT;
					end else begin
						res_d.motion_cmd = MC_MOVE_NEG;
						res_d.move_steps = {1'b0, fast_travel_q};
						res_d.move_speed = fast_speed_q;
						phase_d          = PH_FAST;
						elapsed_d        = '0;
					end
				end
			end
			PH_FAST: begin
				if (endstop_hit) begin
					res_d.motion_cmd = MC_STOP_NOW;
					phase_d          = PH_FAST_HIT;
				end else if (elapsed_inc > approach_to_q) begin
					res_d.motion_cmd = MC_STOP_DEC;
					finish           = 1'b1;
					cause            = FC_FAST_TO;
				end else if (!motion_busy) begin
					res_d.motion_cmd = MC_STOP_DEC;
					finish           = 1'b1;
					cause            = FC_FAST_STALL;
				end
			end
			PH_FAST_HIT: begin
				// The backoff is issued regardless of this sample.
				res_d.motion_cmd = MC_MOVE_POS;
				res_d.move_steps = {1'b0, backoff_q};
				res_d.move_speed = fast_speed_q;
				phase_d          = PH_BACKOFF;
				elapsed_d        = '0;
			end
			PH_BACKOFF: begin
				if (!motion_busy) begin
					if (endstop_hit) begin
						finish = 1'b1;
						cause  = FC_HIT_AFTER_BACK;
					end else begin
						res_d.motion_cmd = MC_MOVE_NEG;
						res_d.move_steps = {1'b0, slow_travel_q};
						res_d.move_speed = slow_speed_q;
						phase_d          = PH_SLOW;
						elapsed_d        = '0;
					end
				end else if (elapsed_inc > backoff_to_q) begin
					finish = 1'b1;
					cause  = FC_BACKOFF_TO;
				end
			end
			PH_SLOW: begin
				if (endstop_hit) begin
					res_d.motion_cmd = MC_STOP_NOW;
					finish           = 1'b1;
					cause            = FC_NONE;
				end else if (elapsed_inc > approach_to_q) begin
					res_d.motion_cmd = MC_STOP_DEC;
					finish           = 1'b1;
					cause            = FC_SLOW_TO;
				end else if (!motion_busy) begin
					res_d.motion_cmd = MC_STOP_DEC;
					finish           = 1'b1;
					cause            = FC_SLOW_STALL;
				end
			end
			default: begin
				phase_d   = PH_IDLE;
				elapsed_d = '0;
			end
		endcase

		// End of a run, successful or not.
		if (finish) begin
			phase_d             = PH_IDLE;
			elapsed_d           = '0;
			res_d.zero_position = 1'b1;
			res_d.fail_cause    = fail_cause_t'(cause);
			if (cause == FC_NONE) begin
				homed_d      = 1'b1;
				res_d.status = ST_DONE;
			end else begin
				res_d.status = ST_FAIL;
			end
		end

		if (phase_d != PH_IDLE) begin
			res_d.driver_enable = 1'b1;
			res_d.status        = ST_BUSY;
		end
		res_d.is_homed = homed_d;
	end

	// Result buffer control: output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_stall) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_accept) begin
			if (out_valid_q && out_stall) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result buffer payload.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_stall) begin
				out_q <= skid_q;
			end
		end else if (in_accept) begin
			if (out_valid_q && out_stall) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign motion_cmd    = out_q.motion_cmd;
	assign move_steps    = out_q.move_steps;
	assign move_speed    = out_q.move_speed;
	assign driver_enable = out_q.driver_enable;
	assign zero_position = out_q.zero_position;
	assign status        = out_q.status;
	assign fail_cause    = out_q.fail_cause;
	assign is_homed      = out_q.is_homed;

	// The skid entry is only ever filled behind a waiting output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	// A finished run pulses zero_position with a final status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_position) |-> (status == ST_DONE || status == ST_FAIL))
		else $error("zero_position without a final status");

	// A failure cause is reported only with a failed status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fail_cause != FC_NONE) |-> (status == ST_FAIL))
		else $error("failure cause without failed status");

	// The driver is enabled exactly while a run is busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (driver_enable == (status == ST_BUSY)))
		else $error("driver enable disagrees with busy status");

	// Once homed, the homed flag stays set.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(homed_q) |-> homed_q)
		else $error("homed flag was cleared");

endmodule : endstop_homing_sequencer_core
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Homing sequencer core testbench
// Drives sample and start transactions into the core and predicts each result
// with a cycle-free model of the homing phases. Directed runs cover every
// failure cause, the pre-clear path, ignored starts, moves that never start and register
// extremes; goal-driven random runs then sweep several register settings
// under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
	import esh_pkg::*;

	// Quiet cycles allowed before the run is declared hung.
	localparam int unsigned QUIET_LIMIT = 4000;
	// Cycles to let the core settle after the last result.
	localparam int unsigned DRAIN_CYCLES = 4;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                command = 1'b0;
	logic                endstop_hit = 1'b0;
	logic                motion_busy = 1'b0;
	logic                ms_tick = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [2:0]          motion_cmd;
	logic [MOVE_W-1:0]   move_steps;
	logic [SPEED_W-1:0]  move_speed;
	logic                driver_enable;
	logic                zero_position;
	logic [1:0]          status;
	logic [3:0]          fail_cause;
	logic                is_homed;

	// Predicted homing state and register copies.
	phase_t              ph;
	logic [MS_W-1:0]     elapsed;
	logic                homed;
	logic [STEPS_W-1:0]  fast_travel, slow_travel, backoff;
	logic [MS_W-1:0]     approach_to, backoff_to, preclear_to;
	logic [SPEED_W-1:0]  fast_spd, slow_spd;

	// Results predicted but not yet seen at the output.
	res_t                pending_res[$];

	bit                  idle_en = 1'b1;
	bit                  noise_on = 1'b0;
	int unsigned         n_items = 0;
	int unsigned         n_results = 0;
	int unsigned         n_mismatch = 0;
	int unsigned         n_homed = 0;
	int unsigned         n_failed = 0;
	int unsigned         n_settings = 0;
	int unsigned         quiet_cycles = 0;
	int unsigned         stall_left = 0;

	endstop_homing_sequencer_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.endstop_hit   (endstop_hit),
		.motion_busy   (motion_busy),
		.ms_tick       (ms_tick),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.motion_cmd    (motion_cmd),
		.move_steps    (move_steps),
		.move_speed    (move_speed),
		.driver_enable (driver_enable),
		.zero_position (zero_position),
		.status        (status),
		.fail_cause    (fail_cause),
		.is_homed      (is_homed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Homing predictor
	// ------------------------------------------------------------------

	// Closes a run: pulses zero, reports success or the failure cause.
	function automatic void end_run(inout res_t r, input fail_cause_t cause);
		ph = PH_IDLE;
		elapsed = '0;
		r.zero_position = 1'b1;
		r.fail_cause = cause;
		if (cause == FC_NONE) begin
			homed = 1'b1;
			r.status = ST_DONE;
			n_homed++;
		end else begin
			r.status = ST_FAIL;
			n_failed++;
		end
	endfunction

	function automatic void set_move(inout res_t r, input motion_cmd_t dir,
			input logic [MOVE_W-1:0] steps, input logic [SPEED_W-1:0] spd);
		r.motion_cmd = dir;
		r.move_steps = steps;
		r.move_speed = spd;
	endfunction

	// Advances the predicted phase by one transaction and returns its result.
	function automatic res_t home_step(input logic start, hit, busy, tick);
		res_t r;
		r = '0;
		if (ph != PH_IDLE && tick && elapsed != MS_MAX)
			elapsed = elapsed + 1'b1;
		case (ph)
			PH_IDLE: begin
				if (start) begin
					elapsed = '0;
					if (hit) begin
						set_move(r, MC_MOVE_POS, {backoff, 1'b0}, fast_spd);
						ph = PH_PRECLEAR;
					end else begin
						set_move(r, MC_MOVE_NEG, {1'b0, fast_travel}, fast_spd);
						ph = PH_FAST;
					end
				end
			end
			PH_PRECLEAR: begin
				if (!busy) begin
					ph = PH_SETTLE;
					elapsed = '0;
				end else if (elapsed > preclear_to) begin
					end_run(r, FC_PRECLEAR_TO);
				end
			end
			PH_SETTLE: begin
				if (elapsed >= SETTLE_MS_DEF) begin
					if (hit) begin
						end_run(r, FC_STILL_HIT);
					end else begin
						set_move(r, MC_MOVE_NEG, {1'b0, fast_travel}, fast_spd);
						ph = PH_FAST;
						elapsed = '0;
					end
				end
			end
			PH_FAST: begin
				if (hit) begin
					r.motion_cmd = MC_STOP_NOW;
					ph = PH_FAST_HIT;
				end else if (elapsed > approach_to) begin
					r.motion_cmd = MC_STOP_DEC;
					end_run(r, FC_FAST_TO);
				end else if (!busy) begin
					r.motion_cmd = MC_STOP_DEC;
					end_run(r, FC_FAST_STALL);
				end
			end
			PH_FAST_HIT: begin
				set_move(r, MC_MOVE_POS, {1'b0, backoff}, fast_spd);
				ph = PH_BACKOFF;
				elapsed = '0;
			end
			PH_BACKOFF: begin
				if (!busy) begin
					if (hit) begin
						end_run(r, FC_HIT_AFTER_BACK);
					end else begin
						set_move(r, MC_MOVE_NEG, {1'b0, slow_travel}, slow_spd);
						ph = PH_SLOW;
						elapsed = '0;
					end
				end else if (elapsed > backoff_to) begin
					end_run(r, FC_BACKOFF_TO);
				end
			end
			PH_SLOW: begin
				if (hit) begin
					r.motion_cmd = MC_STOP_NOW;
					end_run(r, FC_NONE);
				end else if (elapsed > approach_to) begin
					r.motion_cmd = MC_STOP_DEC;
					end_run(r, FC_SLOW_TO);
				end else if (!busy) begin
					r.motion_cmd = MC_STOP_DEC;
					end_run(r, FC_SLOW_STALL);
				end
			end
			default: begin
				ph = PH_IDLE;
				elapsed = '0;
			end
		endcase
		if (ph != PH_IDLE) begin
			r.driver_enable = 1'b1;
			r.status = ST_BUSY;
		end
		r.is_homed = homed;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Transaction drivers
	// ------------------------------------------------------------------

	// Sends one input transaction, with an optional gap before it.
	task automatic send_item(input logic cmd, hit, busy, tick);
		int unsigned gap;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		endstop_hit <= hit;
		motion_busy <= busy;
		ms_tick     <= tick;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		pending_res.push_back(home_step(cmd, hit, busy, tick));
		n_items++;
	endtask

	// Stops sending and waits until every predicted result has come out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_FAST_TRAVEL: fast_travel = val;
			REG_SLOW_TRAVEL: slow_travel = val;
			REG_BACKOFF:     backoff = val;
			REG_APPROACH_TO: approach_to = val[MS_W-1:0];
			REG_BACKOFF_TO:  backoff_to = val[MS_W-1:0];
			REG_PRECLEAR_TO: preclear_to = val[MS_W-1:0];
			REG_FAST_SPEED:  fast_spd = val[SPEED_W-1:0];
			REG_SLOW_SPEED:  slow_spd = val[SPEED_W-1:0];
			default: ;
		endcase
	endtask

	// Rewrites all registers once the core has drained.
	task automatic load_regs(input logic [CFG_W-1:0] ft, st, bo, at, bt, pt, fs, ss);
		wait_idle();
		write_reg(REG_FAST_TRAVEL, ft);
		write_reg(REG_SLOW_TRAVEL, st);
		write_reg(REG_BACKOFF, bo);
		write_reg(REG_APPROACH_TO, at);
		write_reg(REG_BACKOFF_TO, bt);
		write_reg(REG_PRECLEAR_TO, pt);
		write_reg(REG_FAST_SPEED, fs);
		write_reg(REG_SLOW_SPEED, ss);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Plays the motion generator and endstop through one homing run, steering
	// it toward the given outcome. Returns once the core is idle again.
	task automatic run_homing(input fail_cause_t goal, input logic pre_hit);
		phase_t      seen;
		int unsigned n;
		int unsigned len;
		logic        cmd, hit, busy, tick;
		send_item(1'b1, pre_hit, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		seen = ph;
		n = 0;
		len = $urandom_range(0, 8);
		while (ph != PH_IDLE) begin
			if (ph != seen) begin
				seen = ph;
				n = 0;
				len = $urandom_range(0, 8);
			end
			cmd  = 1'b0;
			tick = ($urandom_range(0, 3) != 0);
			hit  = 1'($urandom_range(0, 1));
			busy = 1'b1;
			case (ph)
				PH_PRECLEAR: busy = (goal == FC_PRECLEAR_TO) || (n < len);
				PH_SETTLE: begin
					if (goal == FC_STILL_HIT)
						hit = 1'b1;
					else if (elapsed + tick >= SETTLE_MS_DEF)
						hit = 1'b0;
				end
				PH_FAST: begin
					if (goal == FC_FAST_TO) begin
						hit = 1'b0;
					end else if (goal == FC_FAST_STALL) begin
						hit = 1'b0;
						busy = (n < len);
					end else begin
						hit = (n >= len);
					end
				end
				PH_FAST_HIT: busy = 1'($urandom_range(0, 1));
				PH_BACKOFF: begin
					busy = (goal == FC_BACKOFF_TO) || (n < len);
					if (!busy)
						hit = (goal == FC_HIT_AFTER_BACK);
				end
				PH_SLOW: begin
					if (goal == FC_SLOW_TO) begin
						hit = 1'b0;
					end else if (goal == FC_SLOW_STALL) begin
						hit = 1'b0;
						busy = (n < len);
					end else begin
						hit = (n >= len);
					end
				end
				default: ;
			endcase
			// Occasional junk sample, including starts while a run is active.
			if (noise_on && $urandom_range(0, 11) == 0)
				{cmd, hit, busy, tick} = 4'($urandom);
			send_item(cmd, hit, busy, tick);
			n++;
		end
	endtask

	function automatic fail_cause_t pick_goal();
		fail_cause_t g;
		bit          short_limits;
		short_limits = (approach_to <= 100) && (backoff_to <= 100) && (preclear_to <= 100);
		g = fail_cause_t'($urandom_range(0, 8));
		if ($urandom_range(0, 2) == 0)
			g = FC_NONE;
		if (!short_limits && g inside {FC_PRECLEAR_TO, FC_FAST_TO, FC_BACKOFF_TO, FC_SLOW_TO})
			g = FC_NONE;
		return g;
	endfunction

	function automatic logic [CFG_W-1:0] pick_steps();
		case ($urandom_range(0, 3))
			0: return CFG_W'($urandom_range(1, 64));
			1: return CFG_W'($urandom);
			2: return {CFG_W{1'b1}};
			default: return CFG_W'($urandom_range(0, 5000));
		endcase
	endfunction

	// Millisecond limit with random bits above the register width.
	function automatic logic [CFG_W-1:0] pick_limit(input bit short_limits);
		if (short_limits)
			return {2'($urandom), 22'($urandom_range(0, 40))};
		return {2'($urandom), 22'($urandom_range(1000, 4194303))};
	endfunction

	function automatic logic [CFG_W-1:0] pick_speed();
		return {8'($urandom), 16'($urandom_range(0, 65535))};
	endfunction

	// Goal-driven runs with idle samples in between.
	task automatic random_runs(input int unsigned count);
		int unsigned stop_at;
		fail_cause_t goal;
		stop_at = n_items + count;
		while (n_items < stop_at) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					send_item(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			goal = pick_goal();
			run_homing(goal, (goal inside {FC_PRECLEAR_TO, FC_STILL_HIT}) ||
				($urandom_range(0, 3) == 0));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Idle samples, then a clean two-pass run with the reset register values.
	task automatic test_default_run();
		int unsigned k;
		for (k = 0; k < 8; k++)
			send_item(1'b0, k[0], k[1], k[2]);
		send_item(1'b1, 1'b0, 1'b0, 1'b0);
		send_item(1'b0, 1'b0, 1'b1, 1'b1);
		send_item(1'b0, 1'b1, 1'b1, 1'b0);
		send_item(1'b0, 1'b1, 1'b1, 1'b1);
		send_item(1'b0, 1'b1, 1'b1, 1'b1);
		send_item(1'b0, 1'b0, 1'b0, 1'b0);
		send_item(1'b0, 1'b0, 1'b1, 1'b1);
		send_item(1'b0, 1'b1, 1'b1, 1'b0);
	endtask

	// Ignored start, trip followed by any sample, and moves that never start.
	task automatic test_protocol_corners();
		send_item(1'b1, 1'b0, 1'b0, 1'b0);
		send_item(1'b1, 1'b0, 1'b1, 1'b1);
		send_item(1'b0, 1'b1, 1'b0, 1'b0);
		send_item(1'b1, 1'b1, 1'b0, 1'b1);
		send_item(1'b0, 1'b0, 1'b0, 1'b0);
		send_item(1'b0, 1'b0, 1'b0, 1'b0);
		send_item(1'b1, 1'b0, 1'b0, 1'b0);
		send_item(1'b0, 1'b0, 1'b0, 1'b1);
	endtask

	// Endstop made at start: cleared and settled, then still made.
	task automatic test_preclear();
		run_homing(FC_NONE, 1'b1);
		run_homing(FC_STILL_HIT, 1'b1);
	endtask

	// Short limits so that each failure cause can be reached in turn.
	task automatic test_failure_causes();
		int c;
		load_regs(pick_steps(), pick_steps(), pick_steps(), {2'b11, 22'd12},
			24'd12, {2'b10, 22'd12}, pick_speed(), pick_speed());
		for (c = 1; c <= 8; c++)
			run_homing(fail_cause_t'(c), c <= 2);
	endtask

	// All ones and all zeros in every register.
	task automatic test_register_extremes();
		load_regs({CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}},
			{CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}});
		run_homing(FC_NONE, 1'b1);
		run_homing(FC_NONE, 1'b0);
		load_regs('0, '0, '0, '0, '0, '0, '0, '0);
		random_runs(60);
	endtask

	// Several random register settings with random gaps and stalls.
	task automatic test_random_sweep();
		int unsigned s;
		bit          short_limits;
		noise_on = 1'b1;
		for (s = 0; s < 7; s++) begin
			short_limits = (s % 2 == 0);
			load_regs(pick_steps(), pick_steps(), pick_steps(), pick_limit(short_limits),
				pick_limit(short_limits), pick_limit(short_limits),
				pick_speed(), pick_speed());
			idle_en = ($urandom_range(0, 3) != 0);
			random_runs(100);
		end
	endtask

	// Full rate on both sides for the last stretch.
	task automatic test_quiet_tail();
		idle_en = 1'b0;
		load_regs(pick_steps(), pick_steps(), pick_steps(), pick_limit(1'b1),
			pick_limit(1'b1), pick_limit(1'b1), pick_speed(), pick_speed());
		random_runs(300);
	endtask

	// ------------------------------------------------------------------
	// Output side: random stall bursts and result checking
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (idle_en && stall_left == 0 && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 10);
		if (!idle_en)
			stall_left = 0;
		out_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	task automatic check_field(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("result %0d: %s expected %0d, got %0d", n_results, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_res.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("result %0d: transaction with no prediction pending", n_results);
			end else begin
				want = pending_res.pop_front();
				check_field("motion_cmd", 32'(want.motion_cmd), 32'(motion_cmd));
				check_field("move_steps", 32'(want.move_steps), 32'(move_steps));
				check_field("move_speed", 32'(want.move_speed), 32'(move_speed));
				check_field("driver_enable", 32'(want.driver_enable), 32'(driver_enable));
				check_field("zero_position", 32'(want.zero_position), 32'(zero_position));
				check_field("status", 32'(want.status), 32'(status));
				check_field("fail_cause", 32'(want.fail_cause), 32'(fail_cause));
				check_field("is_homed", 32'(want.is_homed), 32'(is_homed));
			end
			n_results++;
		end
	end

	// Watchdog on cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles > QUIET_LIMIT) begin
			$display("no transaction for %0d cycles", QUIET_LIMIT);
			$display("endstop_homing_sequencer_core: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		ph          = PH_IDLE;
		elapsed     = '0;
		homed       = 1'b0;
		fast_travel = FAST_TRAVEL_RST;
		slow_travel = SLOW_TRAVEL_RST;
		backoff     = BACKOFF_RST;
		approach_to = APPROACH_TO_RST;
		backoff_to  = BACKOFF_TO_RST;
		preclear_to = PRECLEAR_TO_RST;
		fast_spd    = FAST_SPEED_RST;
		slow_spd    = SLOW_SPEED_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_run();
		test_protocol_corners();
		test_preclear();
		test_failure_causes();
		test_register_extremes();
		test_random_sweep();
		test_quiet_tail();
		wait_idle();

		$display("checked %0d results from %0d input transactions over %0d register settings",
			n_results, n_items, n_settings);
		$display("homing runs predicted: %0d successful, %0d failed", n_homed, n_failed);
		if (n_mismatch == 0 && pending_res.size() == 0)
			$display("endstop_homing_sequencer_core: match");
		else
			$display("endstop_homing_sequencer_core: mismatch");
		$finish;
	end

endmodule
